// File: design/camera_ray_direction_top_defines.svh
// assertion macros shared by the camera ray direction block
// expects clk and rst_n in the scope of the module that uses them
`ifndef CAMERA_RAY_DIRECTION_TOP_DEFINES_SVH
`define CAMERA_RAY_DIRECTION_TOP_DEFINES_SVH

// same-cycle implication
`define CRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/crd_pkg.sv
// shared constants and types of the camera ray direction block
// no dependencies
package crd_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int RASTER_W  = 16;
    localparam int COMP_W    = 16;
    localparam int STEP_W    = 32;
    localparam int BASIS_W   = 48;
    localparam int CFG_W     = 48;
    localparam int FAC_SHIFT = COORD_FRAC_BITS + 16;
    localparam int FAC_W     = RASTER_W + STEP_W - FAC_SHIFT;
    localparam int MAG_W     = 48;
    localparam int NMAG_W    = 24;
    localparam int SUM_W     = 50;
    localparam int ROOT_W    = 26;
    localparam int QUO_W     = 15;
    localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

    localparam logic [BASIS_W-1:0] BASIS_U_RST = 48'h0000_4000_0000;
    localparam logic [BASIS_W-1:0] BASIS_V_RST = 48'h0000_0000_4000;
    localparam logic [BASIS_W-1:0] BASIS_W_RST = 48'h4000_0000_0000;

    typedef enum logic [2:0] {
        CFG_BASIS_U     = 3'd0,
        CFG_BASIS_V     = 3'd1,
        CFG_BASIS_W     = 3'd2,
        CFG_X_STEP      = 3'd3,
        CFG_Y_STEP      = 3'd4,
        CFG_HALF_WIDTH  = 3'd5,
        CFG_HALF_HEIGHT = 3'd6
    } cfg_idx_t;

    // normalised direction on its way to the divider
    typedef struct packed {
        logic [2:0][NMAG_W-1:0] mag;
        logic [2:0]             neg;
        logic                   zero;
    } nvec_t;

endpackage

// File: design/crd_vec.sv
// raster factors and unnormalised ray direction, six stages
// depends on crd_pkg
module crd_vec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [crd_pkg::RASTER_W-1:0]  raster_x,
    input  logic [crd_pkg::RASTER_W-1:0]  raster_y,
    input  logic [crd_pkg::BASIS_W-1:0]   basis_u,
    input  logic [crd_pkg::BASIS_W-1:0]   basis_v,
    input  logic [crd_pkg::BASIS_W-1:0]   basis_w,
    input  logic [crd_pkg::STEP_W-1:0]    x_step,
    input  logic [crd_pkg::STEP_W-1:0]    y_step,
    input  logic [crd_pkg::RASTER_W-1:0]  half_width,
    input  logic [crd_pkg::RASTER_W-1:0]  half_height,
    output logic                          out_valid,
    output logic [2:0][crd_pkg::MAG_W-1:0] mag,
    output logic [2:0]                    neg
);
    import crd_pkg::*;

    localparam int PROD_W = FAC_W + 1 + COMP_W;

    logic [5:0] v_reg;
    logic [5:0] v_next;

    logic [RASTER_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic                nx_reg, ny_reg, nx_next, ny_next;

    logic [FAC_W-1:0] ax_reg, ay_reg, ax_next, ay_next;
    logic             nx2_reg, ny2_reg;

    logic signed [FAC_W:0] alpha_reg, beta_reg, alpha_next, beta_next;

    logic signed [PROD_W-1:0] pu_reg [3];
    logic signed [PROD_W-1:0] pv_reg [3];
    logic signed [COMP_W-1:0] cw_reg [3];
    logic signed [PROD_W-1:0] pu_next [3];
    logic signed [PROD_W-1:0] pv_next [3];

    logic signed [MAG_W-1:0] c_reg [3];
    logic signed [MAG_W-1:0] c_next [3];

    logic [2:0][MAG_W-1:0] mag_reg, mag_next;
    logic [2:0]            neg_reg, neg_next;

    assign v_next = {v_reg[4:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        nx_next = raster_x < half_width;
        dx_next = nx_next ? (half_width - raster_x) : (raster_x - half_width);
        ny_next = half_height < raster_y;
        dy_next = ny_next ? (raster_y - half_height) : (half_height - raster_y);
    end

    // magnitude times step, truncated toward zero
    always_comb
    begin
        logic [RASTER_W+STEP_W-1:0] px;
        logic [RASTER_W+STEP_W-1:0] py;
        px = {{STEP_W{1'b0}}, dx_reg} * {{RASTER_W{1'b0}}, x_step};
        py = {{STEP_W{1'b0}}, dy_reg} * {{RASTER_W{1'b0}}, y_step};
        ax_next = px[RASTER_W+STEP_W-1:FAC_SHIFT];
        ay_next = py[RASTER_W+STEP_W-1:FAC_SHIFT];
    end

    always_comb
    begin
        alpha_next = nx2_reg ? -$signed({1'b0, ax_reg}) : $signed({1'b0, ax_reg});
        beta_next  = ny2_reg ? -$signed({1'b0, ay_reg}) : $signed({1'b0, ay_reg});
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pu_next[k] = alpha_reg * $signed(basis_u[COMP_W*k +: COMP_W]);
            pv_next[k] = beta_reg  * $signed(basis_v[COMP_W*k +: COMP_W]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_next[k] = MAG_W'(pu_reg[k]) + MAG_W'(pv_reg[k])
                      - (MAG_W'(cw_reg[k]) <<< 16);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg_next[k] = c_reg[k][MAG_W-1];
            mag_next[k] = neg_next[k] ? MAG_W'(-c_reg[k]) : MAG_W'(c_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            nx2_reg   <= nx_reg;
            ny2_reg   <= ny_reg;
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
            for (int k = 0; k < 3; k++)
            begin
                pu_reg[k] <= pu_next[k];
                pv_reg[k] <= pv_next[k];
                cw_reg[k] <= $signed(basis_w[COMP_W*k +: COMP_W]);
                c_reg[k]  <= c_next[k];
            end
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    assign out_valid = v_reg[5];
    assign mag       = mag_reg;
    assign neg       = neg_reg;

endmodule

// File: design/crd_norm.sv
// block normalisation to 24 bits and sum of squares, four stages
// depends on crd_pkg
module crd_norm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [2:0][crd_pkg::MAG_W-1:0] mag,
    input  logic [2:0]                     neg,
    output logic                           out_valid,
    output crd_pkg::nvec_t                 nv,
    output logic [crd_pkg::SUM_W-1:0]      sum
);
    import crd_pkg::*;

    logic [3:0] v_reg;
    logic [3:0] v_next;

    logic [2:0][MAG_W-1:0] m1_reg;
    logic [2:0]            n1_reg;
    logic [5:0]            lz_reg, lz_next;
    logic                  z1_reg, z1_next;

    nvec_t nv2_reg, nv2_next;
    nvec_t nv3_reg, nv4_reg;
    logic [2:0][2*NMAG_W-1:0] sq_reg, sq_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    assign v_next = {v_reg[2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // leading zeros of the or of all magnitudes equal those of the largest
    always_comb
    begin
        logic [MAG_W-1:0] all_or;
        all_or  = mag[0] | mag[1] | mag[2];
        z1_next = (all_or == '0);
        lz_next = 6'(MAG_W);
        for (int i = 0; i < MAG_W; i++)
        begin
            if (all_or[i])
            begin
                lz_next = 6'(MAG_W - 1 - i);
            end
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0] sh;
        for (int k = 0; k < 3; k++)
        begin
            sh = m1_reg[k] << lz_reg;
            nv2_next.mag[k] = sh[MAG_W-1 -: NMAG_W];
        end
        nv2_next.neg  = n1_reg;
        nv2_next.zero = z1_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_next[k] = {{NMAG_W{1'b0}}, nv2_reg.mag[k]}
                       * {{NMAG_W{1'b0}}, nv2_reg.mag[k]};
        end
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= mag;
            n1_reg  <= neg;
            lz_reg  <= lz_next;
            z1_reg  <= z1_next;
            nv2_reg <= nv2_next;
            sq_reg  <= sq_next;
            nv3_reg <= nv2_reg;
            sum_reg <= sum_next;
            nv4_reg <= nv3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign nv        = nv4_reg;
    assign sum       = sum_reg;

endmodule

// File: design/crd_sqrt.sv
// integer square root, one result bit per stage, 26 stages
// depends on crd_pkg and camera_ray_direction_top_defines.svh
`include "camera_ray_direction_top_defines.svh"

module crd_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  crd_pkg::nvec_t             nv_in,
    input  logic [crd_pkg::SUM_W-1:0]  sum,
    output logic                       out_valid,
    output crd_pkg::nvec_t             nv_out,
    output logic [crd_pkg::ROOT_W-1:0] root
);
    import crd_pkg::*;

    localparam int NSTG = ROOT_W;
    localparam int AW   = 2 * ROOT_W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    logic [AW-1:0] rem_reg  [NSTG];
    logic [AW-1:0] rt_reg   [NSTG];
    nvec_t         nv_reg   [NSTG];
    logic [AW-1:0] rem_in   [NSTG];
    logic [AW-1:0] rt_in    [NSTG];
    nvec_t         nv_stg   [NSTG];
    logic [AW-1:0] rem_next [NSTG];
    logic [AW-1:0] rt_next  [NSTG];

    assign v_next = {v_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        localparam logic [AW-1:0] BIT = AW'(1) << (AW - 2 - 2 * k);

        if (k == 0)
        begin : g_first
            assign rem_in[k] = AW'(sum);
            assign rt_in[k]  = '0;
            assign nv_stg[k] = nv_in;
        end
        else
        begin : g_rest
            assign rem_in[k] = rem_reg[k-1];
            assign rt_in[k]  = rt_reg[k-1];
            assign nv_stg[k] = nv_reg[k-1];
        end

        always_comb
        begin
            logic [AW-1:0] trial;
            trial = rt_in[k] + BIT;
            if (rem_in[k] >= trial)
            begin
                rem_next[k] = rem_in[k] - trial;
                rt_next[k]  = (rt_in[k] >> 1) + BIT;
            end
            else
            begin
                rem_next[k] = rem_in[k];
                rt_next[k]  = rt_in[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[k];
                rt_reg[k]  <= rt_next[k];
                nv_reg[k]  <= nv_stg[k];
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign nv_out    = nv_reg[NSTG-1];
    assign root      = rt_reg[NSTG-1][ROOT_W-1:0];

    // normalised vector has its largest component at or above 2^23
    `CRD_ASSERT_NOW(a_root_normalised, out_valid && !nv_out.zero,
        root[ROOT_W-1:NMAG_W-1] != '0, "root below normalised range")

    `CRD_ASSERT_NOW(a_root_zero, out_valid && nv_out.zero,
        root == '0, "root of zero vector is not zero")

endmodule

// File: design/crd_div.sv
// rounded division of each component by the root, one quotient bit per stage
// depends on crd_pkg
module crd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  crd_pkg::nvec_t             nv,
    input  logic [crd_pkg::ROOT_W-1:0] root,
    output logic                       out_valid,
    output logic signed [crd_pkg::COMP_W-1:0] dir_x,
    output logic signed [crd_pkg::COMP_W-1:0] dir_y,
    output logic signed [crd_pkg::COMP_W-1:0] dir_z
);
    import crd_pkg::*;

    localparam int RW   = ROOT_W + QUO_W - 1;
    localparam int NSTG = QUO_W;

    typedef struct packed {
        logic [2:0][RW-1:0]    rem;
        logic [2:0][QUO_W-1:0] quo;
        logic [ROOT_W-1:0]     div;
        logic [2:0]            neg;
        logic                  zero;
    } dstg_t;

    logic [NSTG+1:0] v_reg;
    logic [NSTG+1:0] v_next;

    dstg_t prep_reg, prep_next;
    dstg_t st_reg  [NSTG];
    dstg_t st_in   [NSTG];
    dstg_t st_next [NSTG];

    logic [2:0][COMP_W-1:0] dir_reg, dir_next;

    assign v_next = {v_reg[NSTG:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // dividend with half the divisor added for rounding
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prep_next.rem[k] = (RW'(nv.mag[k]) << 14) + RW'(root >> 1);
        end
        prep_next.quo  = '0;
        prep_next.div  = root;
        prep_next.neg  = nv.neg;
        prep_next.zero = nv.zero;
    end

    for (genvar j = 0; j < NSTG; j++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - j;

        if (j == 0)
        begin : g_first
            assign st_in[j] = prep_reg;
        end
        else
        begin : g_rest
            assign st_in[j] = st_reg[j-1];
        end

        always_comb
        begin
            logic [RW-1:0] trial;
            st_next[j] = st_in[j];
            trial = RW'(st_in[j].div) << SH;
            for (int k = 0; k < 3; k++)
            begin
                if (st_in[j].rem[k] >= trial)
                begin
                    st_next[j].rem[k]     = st_in[j].rem[k] - trial;
                    st_next[j].quo[k][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    // saturate, restore sign, force zero vector
    always_comb
    begin
        logic [QUO_W-1:0] qc;
        for (int k = 0; k < 3; k++)
        begin
            qc = (st_reg[NSTG-1].quo[k] > ONE_Q14) ? ONE_Q14 : st_reg[NSTG-1].quo[k];
            if (st_reg[NSTG-1].zero)
            begin
                dir_next[k] = '0;
            end
            else if (st_reg[NSTG-1].neg[k])
            begin
                dir_next[k] = -{1'b0, qc};
            end
            else
            begin
                dir_next[k] = {1'b0, qc};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
            dir_reg  <= dir_next;
        end
    end

    assign out_valid = v_reg[NSTG+1];
    assign dir_x     = dir_reg[0];
    assign dir_y     = dir_reg[1];
    assign dir_z     = dir_reg[2];

endmodule

// File: design/camera_ray_direction_top.sv
// camera ray direction: pinhole primary ray generation, top level
// depends on crd_pkg, crd_vec, crd_norm, crd_sqrt, crd_div and the defines header
//
// input words carry one raster position (x, y in unsigned q12.4); each gives
// exactly one output word with the unit ray direction (x, y, z in signed q1.14)
// the camera basis, steps and half extents are loaded over the write port
// (cfg_we, cfg_index, cfg_wdata) while no word is in flight; the user must keep to this, the
// block itself does not enforce it; index 7 is ignored
// the pipeline runs through the factors and direction vector, block normalisation and the
// sum of squares, the square root (one bit per stage) and the divider (one quotient bit per
// stage plus set-up and output registers); throughput is one word per cycle while the
// output word is not held; the whole pipeline advances together
// the pipeline stalls as a unit while the output word is held and not taken,
// so s_axis_tready drops only then; nothing is lost or repeated
// reset clears all valid bits and loads the default basis, zero steps and
// zero half extents
`include "camera_ray_direction_top_defines.svh"

module camera_ray_direction_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // raster_x, raster_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // dir_x, dir_y, dir_z
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [crd_pkg::CFG_W-1:0] cfg_wdata
);
    import crd_pkg::*;

    logic [BASIS_W-1:0]  basis_u_reg, basis_v_reg, basis_w_reg;
    logic [STEP_W-1:0]   x_step_reg, y_step_reg;
    logic [RASTER_W-1:0] half_width_reg, half_height_reg;

    logic en;

    logic                  vec_valid;
    logic [2:0][MAG_W-1:0] vec_mag;
    logic [2:0]            vec_neg;
    logic                  norm_valid;
    nvec_t                 norm_nv;
    logic [SUM_W-1:0]      norm_sum;
    logic                  sqrt_valid;
    nvec_t                 sqrt_nv;
    logic [ROOT_W-1:0]     sqrt_root;
    logic signed [COMP_W-1:0] dir_x, dir_y, dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_u_reg     <= BASIS_U_RST;
            basis_v_reg     <= BASIS_V_RST;
            basis_w_reg     <= BASIS_W_RST;
            x_step_reg      <= '0;
            y_step_reg      <= '0;
            half_width_reg  <= '0;
            half_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASIS_U:     basis_u_reg     <= cfg_wdata[BASIS_W-1:0];
                CFG_BASIS_V:     basis_v_reg     <= cfg_wdata[BASIS_W-1:0];
                CFG_BASIS_W:     basis_w_reg     <= cfg_wdata[BASIS_W-1:0];
                CFG_X_STEP:      x_step_reg      <= cfg_wdata[STEP_W-1:0];
                CFG_Y_STEP:      y_step_reg      <= cfg_wdata[STEP_W-1:0];
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_wdata[RASTER_W-1:0];
                CFG_HALF_HEIGHT: half_height_reg <= cfg_wdata[RASTER_W-1:0];
                default:         ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    crd_vec u_vec (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .raster_x    (s_axis_tdata[15:0]),
        .raster_y    (s_axis_tdata[31:16]),
        .basis_u     (basis_u_reg),
        .basis_v     (basis_v_reg),
        .basis_w     (basis_w_reg),
        .x_step      (x_step_reg),
        .y_step      (y_step_reg),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .out_valid   (vec_valid),
        .mag         (vec_mag),
        .neg         (vec_neg)
    );

    crd_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vec_valid),
        .mag       (vec_mag),
        .neg       (vec_neg),
        .out_valid (norm_valid),
        .nv        (norm_nv),
        .sum       (norm_sum)
    );

    crd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .nv_in     (norm_nv),
        .sum       (norm_sum),
        .out_valid (sqrt_valid),
        .nv_out    (sqrt_nv),
        .root      (sqrt_root)
    );

    crd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .nv        (sqrt_nv),
        .root      (sqrt_root),
        .out_valid (m_axis_tvalid),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z)
    );

    assign m_axis_tdata = {dir_z, dir_y, dir_x};

    `CRD_ASSERT_NOW(a_ready_tracks_sink, 1'b1,
        s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow sink")

    `CRD_ASSERT_NOW(a_dir_x_unit, m_axis_tvalid,
        (dir_x <= 16'sd16384) && (dir_x >= -16'sd16384), "dir_x beyond unit range")

    `CRD_ASSERT_NOW(a_dir_yz_unit, m_axis_tvalid,
        (dir_y <= 16'sd16384) && (dir_y >= -16'sd16384) &&
        (dir_z <= 16'sd16384) && (dir_z >= -16'sd16384), "dir_y or dir_z beyond unit range")

endmodule

// File: verif/camera_ray_direction_top_test.sv
// testbench for the camera ray direction block: directed table, then random rasters
// depends on crd_pkg and camera_ray_direction_top; predicts each unit direction itself
module camera_ray_direction_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import crd_pkg::*;

    // register index that no register answers to
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // raster_x, raster_y
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // dir_x, dir_y, dir_z
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    camera_ray_direction_top u_dut (.*);

    // camera settings as the predictor sees them
    logic [47:0] cam_u, cam_v, cam_w;
    logic [31:0] cam_xstep, cam_ystep;
    logic [15:0] cam_hw, cam_hh;

    logic [47:0] dir_queue[$];
    int  errors;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  stim_done;

    initial begin
        clk = 1'b0;
    end
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint sext16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint ray_factor(logic [15:0] pos, logic [15:0] neg,
                                          logic [31:0] step);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = (pos >= neg) ? 64'(pos - neg) : 64'(neg - pos);
        prod = (mag * 64'(step)) >> FAC_SHIFT;
        return (pos < neg) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (s >= root + b)
            begin
                s = s - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [47:0] unit_direction(logic [15:0] rx, logic [15:0] ry);
        longint alpha, beta, c;
        logic [63:0] mag[3];
        bit neg[3];
        logic [63:0] m, sum, r, q;
        int len;
        logic [47:0] res;
        alpha = ray_factor(rx, cam_hw, cam_xstep);
        beta  = ray_factor(cam_hh, ry, cam_ystep);
        m = 0;
        sum = 0;
        res = '0;
        for (int k = 0; k < 3; k++)
        begin
            c = alpha * sext16(cam_u[16*k +: 16]) + beta * sext16(cam_v[16*k +: 16])
                - sext16(cam_w[16*k +: 16]) * 65536;
            neg[k] = c < 0;
            mag[k] = neg[k] ? 64'(-c) : 64'(c);
            if (mag[k] > m)
                m = mag[k];
        end
        if (m == 0)
            return res;
        len = 0;
        while (m != 0)
        begin
            len++;
            m = m >> 1;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (len > 24)
                mag[k] = mag[k] >> (len - 24);
            else
                mag[k] = mag[k] << (24 - len);
            sum += mag[k] * mag[k];
        end
        r = floor_sqrt(sum);
        for (int k = 0; k < 3; k++)
        begin
            q = (mag[k] * 16384 + (r >> 1)) / r;
            if (q > 16384)
                q = 16384;
            res[16*k +: 16] = neg[k] ? 16'(-q) : 16'(q);
        end
        return res;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_BASIS_U:     cam_u = val;
            CFG_BASIS_V:     cam_v = val;
            CFG_BASIS_W:     cam_w = val;
            CFG_X_STEP:      cam_xstep = val[31:0];
            CFG_Y_STEP:      cam_ystep = val[31:0];
            CFG_HALF_WIDTH:  cam_hw = val[15:0];
            CFG_HALF_HEIGHT: cam_hh = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // unknown index must leave every register alone
    task automatic write_unknown(logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNUSED_IDX;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (dir_queue.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // typed_in picks the known value, otherwise the predictor gives it
    task automatic send_raster(logic [15:0] rx, logic [15:0] ry, logic [47:0] known,
                               bit typed_in);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ry, rx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        dir_queue.push_back(typed_in ? known : unit_direction(rx, ry));
    endtask

    task automatic random_camera(bit extreme);
        write_reg(CFG_BASIS_U, extreme ? 48'hffff_ffff_ffff : 48'({$urandom, $urandom}));
        write_reg(CFG_BASIS_V, extreme ? 48'h8000_8000_8000 : 48'({$urandom, $urandom}));
        write_reg(CFG_BASIS_W, extreme ? 48'h7fff_7fff_7fff : 48'({$urandom, $urandom}));
        write_reg(CFG_X_STEP, extreme ? 48'hffff_ffff : 48'($urandom));
        write_reg(CFG_Y_STEP, extreme ? 48'hffff_ffff : 48'($urandom >> $urandom_range(31)));
        write_reg(CFG_HALF_WIDTH, extreme ? 48'hffff : 48'($urandom_range(65535)));
        write_reg(CFG_HALF_HEIGHT, extreme ? 48'h0 : 48'($urandom_range(65535)));
    endtask

    typedef struct {
        logic [15:0] rx;
        logic [15:0] ry;
        logic [47:0] dir;
        bit          typed_in;
    } raster_row_t;

    raster_row_t directed[$];

    initial begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors = 0;
        stim_done = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cam_u = BASIS_U_RST;
        cam_v = BASIS_V_RST;
        cam_w = BASIS_W_RST;
        cam_xstep = '0;
        cam_ystep = '0;
        cam_hw = '0;
        cam_hh = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset steps are zero: every ray points along -w
        directed.push_back('{16'h0000, 16'h0000, {16'hc000, 16'h0000, 16'h0000}, 1});
        directed.push_back('{16'hffff, 16'hffff, {16'hc000, 16'h0000, 16'h0000}, 1});
        directed.push_back('{16'h8000, 16'h0001, {16'hc000, 16'h0000, 16'h0000}, 1});
        foreach (directed[i])
            send_raster(directed[i].rx, directed[i].ry, directed[i].dir, 1);
        drain_results();

        // degenerate basis gives a zero direction
        write_reg(CFG_BASIS_U, 48'h0);
        write_reg(CFG_BASIS_V, 48'h0);
        write_reg(CFG_BASIS_W, 48'h0);
        write_unknown(48'hffff_ffff_ffff);
        send_raster(16'h1234, 16'hffff, 48'h0, 1);
        send_raster(16'hffff, 16'h0000, 48'h0, 1);
        drain_results();

        // a typical 640x480 camera, then extremes with saturating components
        write_reg(CFG_BASIS_U, 48'h0000_0000_4000);
        write_reg(CFG_BASIS_V, 48'h0000_4000_0000);
        write_reg(CFG_BASIS_W, 48'h4000_0000_0000);
        write_reg(CFG_X_STEP, 48'h0019_a5a5);
        write_reg(CFG_Y_STEP, 48'h0022_3344);
        write_reg(CFG_HALF_WIDTH, 48'd5120);
        write_reg(CFG_HALF_HEIGHT, 48'd3840);
        directed.delete();
        directed.push_back('{16'd5120, 16'd3840, 48'h0, 0});
        directed.push_back('{16'h0000, 16'h0000, 48'h0, 0});
        directed.push_back('{16'hffff, 16'hffff, 48'h0, 0});
        directed.push_back('{16'd10240, 16'd7680, 48'h0, 0});
        directed.push_back('{16'h5555, 16'haaaa, 48'h0, 0});
        foreach (directed[i])
            send_raster(directed[i].rx, directed[i].ry, 48'h0, 0);
        drain_results();
        random_camera(1);
        foreach (directed[i])
            send_raster(directed[i].rx, directed[i].ry, 48'h0, 0);
        send_raster(16'h0000, 16'hffff, 48'h0, 0);
        drain_results();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            random_camera(phase == 7);
            for (int n = 0; n < 215; n++)
            begin
                if ($urandom_range(3) == 0)
                    send_raster(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                48'h0, 0);
                else
                    send_raster(16'(cam_hw + $urandom_range(2047) - 1024),
                                16'(cam_hh + $urandom_range(2047) - 1024), 48'h0, 0);
                if (phase == 3 && n == 100)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (dir_queue.size() != 0)
                        @(posedge clk);
                end
            end
            drain_results();
        end
        stim_done = 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        logic [47:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (dir_queue.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = dir_queue.pop_front();
                for (int k = 0; k < 3; k++)
                    if (want[16*k +: 16] !== m_axis_tdata[16*k +: 16])
                    begin
                        $display("%0t: dir %0d expected %0d actual %0d", $time, k,
                                 $signed(want[16*k +: 16]),
                                 $signed(m_axis_tdata[16*k +: 16]));
                        errors++;
                    end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        if (errors == 0 && dir_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
